// ----- rtl/bis_pkg.sv -----
// Shared types and constants for the bilinear image scaler.
package bis_pkg;
	localparam int unsigned POS_W = 12;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned SIZE_W = 9;
	localparam int unsigned STEP_W = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_X_STEP     = 2'd2,
		REG_Y_STEP     = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_REQUEST = 1'b1
	} kind_t;

	// Item handed from the front end to the back end.
	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [PIX_W-1:0] pixel;
	} cmd_t;
endpackage

// ----- rtl/bis_front.sv -----
// Front end: accepts items, applies the load window and queues them.
module bis_front import bis_pkg::*; #(
	parameter int unsigned DEPTH_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              kind,
	input  logic [POS_W-1:0]  pos_x,
	input  logic [POS_W-1:0]  pos_y,
	input  logic [PIX_W-1:0]  pixel_in,
	input  logic [POS_W:0]    width_eff,
	input  logic [POS_W:0]    height_eff,
	output logic              busy,
	input  logic              pop,
	output logic              cmd_valid,
	output cmd_t              cmd
);
	localparam int unsigned DEPTH = 1 << DEPTH_W;
	cmd_t fifo_q [DEPTH];
	logic [DEPTH_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [DEPTH_W:0] count_q;
	logic push, keep;

	assign busy = (count_q == (DEPTH_W+1)'(DEPTH));
	// drop loads outside the source
	assign keep = (kind == KIND_REQUEST) ||
		(({1'b0, pos_x} < width_eff) && ({1'b0, pos_y} < height_eff));
	assign push = start && !busy && keep;
	assign cmd_valid = (count_q != '0);
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{kind: kind_t'(kind), pos_x: pos_x, pos_y: pos_y,
				pixel: pixel_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (DEPTH_W+1)'(push) - (DEPTH_W+1)'(pop);
		end
	end
endmodule

// ----- rtl/bis_back.sv -----
// Back end: frame store banks and the bilinear blend pipeline.
module bis_back import bis_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              pop,
	input  logic [POS_W:0]    width_eff,
	input  logic [POS_W:0]    height_eff,
	input  logic [STEP_W-1:0] x_step,
	input  logic [STEP_W-1:0] y_step,
	output logic              done,
	output logic [PIX_W-1:0]  pixel_out
);
	localparam int unsigned XW = $clog2(MAX_WIDTH);
	localparam int unsigned YW = $clog2(MAX_HEIGHT);
	localparam int unsigned HXW = (XW > 1) ? XW - 1 : 1;
	localparam int unsigned HYW = (YW > 1) ? YW - 1 : 1;
	localparam int unsigned BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2) + MAX_WIDTH
		+ MAX_HEIGHT;
	localparam int unsigned BA_W = $clog2(BANK_DEPTH);
	localparam int unsigned PW = POS_W + STEP_W;
	localparam int unsigned BW = PIX_W + FRAC_BITS + 1;
	localparam int unsigned HROW = (MAX_WIDTH + 1) / 2;

	assign pop = cmd_valid;

	// stage 1: products
	logic              req_s1, ld_s1;
	logic [PW-1:0]     sx_s1, sy_s1;
	logic [POS_W-1:0]  lx_s1, ly_s1;
	logic [PIX_W-1:0]  lpix_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= 1'b0;
			ld_s1 <= 1'b0;
		end else begin
			req_s1 <= cmd_valid && cmd.kind == KIND_REQUEST;
			ld_s1 <= cmd_valid && cmd.kind == KIND_LOAD;
		end
	end
	always_ff @(posedge clk) begin
		sx_s1 <= PW'(cmd.pos_x) * PW'(x_step);
		sy_s1 <= PW'(cmd.pos_y) * PW'(y_step);
		lx_s1 <= cmd.pos_x;
		ly_s1 <= cmd.pos_y;
		lpix_s1 <= cmd.pixel;
	end

	// stage 2: clamp and neighbour coordinates
	logic [PW-FRAC_BITS-1:0] ix, iy;
	logic [POS_W:0] wl, hl, x1, y1, x2, y2;
	assign ix = sx_s1[PW-1:FRAC_BITS];
	assign iy = sy_s1[PW-1:FRAC_BITS];
	assign wl = width_eff - 1'b1;
	assign hl = height_eff - 1'b1;
	assign x1 = (ix > (PW-FRAC_BITS)'(wl)) ? wl : (POS_W+1)'(ix);
	assign y1 = (iy > (PW-FRAC_BITS)'(hl)) ? hl : (POS_W+1)'(iy);
	assign x2 = (x1 >= wl) ? wl : x1 + 1'b1;
	assign y2 = (y1 >= hl) ? hl : y1 + 1'b1;

	// four banks by (row parity, column parity); bank (ry,rx) at (row/2, col/2)
	function automatic logic [BA_W-1:0] baddr(input logic [POS_W:0] c, input logic [POS_W:0] r);
		return BA_W'(r[HYW:1] * HROW + BA_W'(c[HXW:1]));
	endfunction

	logic [POS_W:0] lx, ly;
	logic [POS_W:0] xe, xo, ye, yo; // even/odd column and row of the 2x2 window
	assign lx = {1'b0, lx_s1};
	assign ly = {1'b0, ly_s1};
	assign xe = x1[0] ? x2 : x1;
	assign xo = x1[0] ? x1 : x2;
	assign ye = y1[0] ? y2 : y1;
	assign yo = y1[0] ? y1 : y2;

	logic [PIX_W-1:0] bank0 [BANK_DEPTH];
	logic [PIX_W-1:0] bank1 [BANK_DEPTH];
	logic [PIX_W-1:0] bank2 [BANK_DEPTH];
	logic [PIX_W-1:0] bank3 [BANK_DEPTH];
	logic [PIX_W-1:0] d_s2 [4];
	logic [1:0] lsel;
	assign lsel = {ly[0], lx[0]};

	always_ff @(posedge clk) begin
		if (ld_s1 && lsel == 2'd0) bank0[baddr(lx, ly)] <= lpix_s1;
		d_s2[0] <= bank0[baddr(xe, ye)];
	end
	always_ff @(posedge clk) begin
		if (ld_s1 && lsel == 2'd1) bank1[baddr(lx, ly)] <= lpix_s1;
		d_s2[1] <= bank1[baddr(xo, ye)];
	end
	always_ff @(posedge clk) begin
		if (ld_s1 && lsel == 2'd2) bank2[baddr(lx, ly)] <= lpix_s1;
		d_s2[2] <= bank2[baddr(xe, yo)];
	end
	always_ff @(posedge clk) begin
		if (ld_s1 && lsel == 2'd3) bank3[baddr(lx, ly)] <= lpix_s1;
		d_s2[3] <= bank3[baddr(xo, yo)];
	end

	logic req_s2, xsw_s2, ysw_s2, xdup_s2, ydup_s2;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) req_s2 <= 1'b0;
		else req_s2 <= req_s1;
	end
	always_ff @(posedge clk) begin
		fx_s2 <= sx_s1[FRAC_BITS-1:0];
		fy_s2 <= sy_s1[FRAC_BITS-1:0];
		xsw_s2 <= x1[0];
		ysw_s2 <= y1[0];
		xdup_s2 <= (x2 == x1);
		ydup_s2 <= (y2 == y1);
	end

	// stage 3: horizontal blends
	function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [FRAC_BITS-1:0] f);
		logic [BW-1:0] s;
		s = BW'(a) * (BW'(1) << FRAC_BITS) - BW'(a) * BW'(f) + BW'(b) * BW'(f);
		return s[FRAC_BITS +: PIX_W];
	endfunction

	logic [PIX_W-1:0] tl, tr_raw, bl_raw, br_raw, tr, bl, br;
	assign tl = xsw_s2 ? (ysw_s2 ? d_s2[3] : d_s2[1]) : (ysw_s2 ? d_s2[2] : d_s2[0]);
	assign tr_raw = xsw_s2 ? (ysw_s2 ? d_s2[2] : d_s2[0]) : (ysw_s2 ? d_s2[3] : d_s2[1]);
	assign bl_raw = xsw_s2 ? (ysw_s2 ? d_s2[1] : d_s2[3]) : (ysw_s2 ? d_s2[0] : d_s2[2]);
	assign br_raw = xsw_s2 ? (ysw_s2 ? d_s2[0] : d_s2[2]) : (ysw_s2 ? d_s2[1] : d_s2[3]);
	// at the last column or row both neighbours are the same pixel
	assign tr = xdup_s2 ? tl : tr_raw;
	assign bl = ydup_s2 ? tl : bl_raw;
	assign br = xdup_s2 ? bl : (ydup_s2 ? tr_raw : br_raw);

	logic req_s3;
	logic [PIX_W-1:0] top_s3, bot_s3;
	logic [FRAC_BITS-1:0] fy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) req_s3 <= 1'b0;
		else req_s3 <= req_s2;
	end
	always_ff @(posedge clk) begin
		top_s3 <= blend(tl, tr, fx_s2);
		bot_s3 <= blend(bl, br, fx_s2);
		fy_s3 <= fy_s2;
	end

	// stage 4: vertical blend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= req_s3;
	end
	always_ff @(posedge clk) begin
		pixel_out <= blend(top_s3, bot_s3, fy_s3);
	end
endmodule

// ----- rtl/bilinear_image_scaler.sv -----
// Top level of the bilinear grey image scaler.
// Items enter on start while busy is low: kind 0 loads a source byte into a
// four-bank frame store, kind 1 requests one destination pixel, returned on
// pixel_out with done high for one cycle. done rises after the item is
// written into the input queue and has passed the back-end registers req_s1,
// req_s2 and req_s3. The back end takes one item per cycle, so busy stays low
// in steady operation; the four banks (split by row and column parity) give
// all four neighbours in one parallel read. The receiver cannot stall, so
// results are never held. Loads outside the source size are dropped. The
// frame store is not cleared; read only pixels that were loaded.
module bilinear_image_scaler import bis_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [POS_W-1:0]      pos_x,
	input  logic [POS_W-1:0]      pos_y,
	input  logic [PIX_W-1:0]      pixel_in,
	output logic                  done,
	output logic [PIX_W-1:0]      pixel_out,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic [SIZE_W-1:0] src_width_q, src_height_q;
	logic [STEP_W-1:0] x_step_q, y_step_q;
	logic [POS_W:0] width_eff, height_eff;
	logic pop, cmd_valid;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= SIZE_W'(256);
			src_height_q <= SIZE_W'(256);
			x_step_q <= STEP_W'(65536);
			y_step_q <= STEP_W'(65536);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q <= cfg_data[SIZE_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SIZE_W-1:0];
				REG_X_STEP:     x_step_q <= cfg_data;
				REG_Y_STEP:     y_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, clip to the store size
	always_comb begin
		width_eff = (src_width_q == '0) ? (POS_W+1)'(1) :
			((32'(src_width_q) > MAX_WIDTH) ? (POS_W+1)'(MAX_WIDTH) : (POS_W+1)'(src_width_q));
		height_eff = (src_height_q == '0) ? (POS_W+1)'(1) :
			((32'(src_height_q) > MAX_HEIGHT) ? (POS_W+1)'(MAX_HEIGHT)
				: (POS_W+1)'(src_height_q));
	end

	bis_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind), .pos_x(pos_x),
		.pos_y(pos_y), .pixel_in(pixel_in), .width_eff(width_eff),
		.height_eff(height_eff), .busy(busy), .pop(pop), .cmd_valid(cmd_valid), .cmd(cmd)
	);

	bis_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd), .pop(pop),
		.width_eff(width_eff), .height_eff(height_eff), .x_step(x_step_q),
		.y_step(y_step_q), .done(done), .pixel_out(pixel_out)
	);
endmodule

// ----- rtl/bis_checker.sv -----
// Port-level checks for the bilinear image scaler, bound to the top level.
module bis_checker import bis_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic done,
	input logic cfg_ready
);
	// a result may not appear too soon after reset is released
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(arst_n, 5)) else $error("result too soon after reset");
	// with start low now and in each past sample checked, done must be low
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!start && $past(!start) && $past(!start, 2) && $past(!start, 3) &&
		 $past(!start, 4) && $past(!start, 5) && $past(!start, 6)) |-> !done)
		else $error("result without request");
	// a lone load never yields a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_LOAD && !$past(start) && !$past(start, 2)
		 && !$past(start, 3) && !$past(start, 4) && !$past(start, 5) && !$past(start, 6))
		|-> ##5 !done) else $error("load produced a result");
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("config port stalled");
endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
	.done(done), .cfg_ready(cfg_ready)
);
